// ----- rtl/core/rsb_pkg.sv -----
package rsb_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_FB_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FB_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_BREAK = 2'd2;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int SIDE_W = 11;

  // Stream command codes
  localparam logic [7:0] CMD_STOP      = 8'hff;
  localparam logic [7:0] LITERAL_LIMIT = 8'h80;
  localparam logic [7:0] RUN_BIAS      = 8'h7c;

  // Pen and flat address widths
  localparam int ROW_W  = 18;
  localparam int COL_W  = 32;
  localparam int XY_W   = 17;
  localparam int BASE_W = 30;
  localparam int SIZE_W = 22;
  localparam int FLAT_W = 34;

  typedef struct packed {
    logic               kind;
    logic [7:0]         stream_byte;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] hot_x;
    logic signed [15:0] hot_y;
    logic [15:0]        sprite_width;
    logic [15:0]        sprite_height;
  } item_t;

  typedef struct packed {
    logic [19:0] write_offset;
    logic [7:0]  write_length;
    logic [7:0]  write_value;
  } span_t;

  // Clamped framebuffer geometry and live row break code
  typedef struct packed {
    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic [7:0]        row_break_code;
  } cfg_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic signed [COL_W-1:0] col;
    logic [7:0]              len;
    logic [7:0]              value;
  } span_req_t;

  typedef struct packed {
    logic  hit;
    span_t span;
  } span_res_t;

endpackage

// ----- rtl/core/rsb_cfg_regs.sv -----
module rsb_cfg_regs #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsb_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsb_pkg::DATA_W-1:0]  pwdata,
  output logic [rsb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rsb_pkg::cfg_t               cfg
);

  logic [rsb_pkg::SIDE_W-1:0] fb_width;
  logic [rsb_pkg::SIDE_W-1:0] fb_height;
  logic [7:0]                 row_break_code;
  logic [1:0]                 reg_index;
  logic                       wr_en;

  function automatic logic [rsb_pkg::SIDE_W-1:0] side_of(input logic [rsb_pkg::SIDE_W-1:0] v);
    logic [rsb_pkg::SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = rsb_pkg::SIDE_W'(1);
    end else if (13'(v) > 13'(MAX_SIDE)) begin
      r = rsb_pkg::SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width       <= rsb_pkg::SIDE_W'(600);
      fb_height      <= rsb_pkg::SIDE_W'(360);
      row_break_code <= 8'd254;
    end else if (wr_en) begin
      unique case (reg_index)
        rsb_pkg::REG_FB_WIDTH:  fb_width       <= pwdata[rsb_pkg::SIDE_W-1:0];
        rsb_pkg::REG_FB_HEIGHT: fb_height      <= pwdata[rsb_pkg::SIDE_W-1:0];
        rsb_pkg::REG_ROW_BREAK: row_break_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_index)
      rsb_pkg::REG_FB_WIDTH:  prdata = rsb_pkg::DATA_W'(fb_width);
      rsb_pkg::REG_FB_HEIGHT: prdata = rsb_pkg::DATA_W'(fb_height);
      rsb_pkg::REG_ROW_BREAK: prdata = rsb_pkg::DATA_W'(row_break_code);
      default:                prdata = '0;
    endcase
  end

  assign cfg.side_w         = side_of(fb_width);
  assign cfg.side_h         = side_of(fb_height);
  assign cfg.row_break_code = row_break_code;

endmodule

// ----- rtl/core/rsb_span_clip.sv -----
module rsb_span_clip (
  input  rsb_pkg::cfg_t      cfg,
  input  rsb_pkg::span_req_t req,
  output rsb_pkg::span_res_t res
);

  logic signed [11:0]                  w_s;
  logic signed [rsb_pkg::BASE_W-1:0]   base;
  logic [rsb_pkg::SIZE_W-1:0]          size;
  logic signed [rsb_pkg::FLAT_W-1:0]   start;
  logic signed [rsb_pkg::FLAT_W-1:0]   stop;
  logic signed [rsb_pkg::FLAT_W-1:0]   last;
  logic signed [rsb_pkg::FLAT_W-1:0]   lo_a;
  logic signed [rsb_pkg::FLAT_W-1:0]   lo;
  logic signed [rsb_pkg::FLAT_W-1:0]   hi;
  logic signed [rsb_pkg::FLAT_W-1:0]   span_len;

  // Flat row base and framebuffer size
  assign w_s  = signed'({1'b0, cfg.side_w});
  assign base = rsb_pkg::BASE_W'(req.row) * rsb_pkg::BASE_W'(w_s);
  assign size = rsb_pkg::SIZE_W'(cfg.side_w) * rsb_pkg::SIZE_W'(cfg.side_h);

  // Clip in the flat domain: keep col >= 0 and offsets inside the buffer
  always_comb begin
    start    = rsb_pkg::FLAT_W'(base) + rsb_pkg::FLAT_W'(req.col);
    stop     = start + signed'(rsb_pkg::FLAT_W'(req.len)) - rsb_pkg::FLAT_W'(1);
    last     = signed'(rsb_pkg::FLAT_W'(size)) - rsb_pkg::FLAT_W'(1);
    lo_a     = (start > rsb_pkg::FLAT_W'(base)) ? start : rsb_pkg::FLAT_W'(base);
    lo       = (lo_a < 0) ? '0 : lo_a;
    hi       = (stop < last) ? stop : last;
    span_len = hi - lo + rsb_pkg::FLAT_W'(1);
    res.hit               = (req.value != 8'd0) && (lo <= hi);
    res.span.write_offset = lo[19:0];
    res.span.write_length = span_len[7:0];
    res.span.write_value  = req.value;
  end

endmodule

// ----- rtl/core/rsb_parser.sv -----
module rsb_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  rsb_pkg::item_t     item,
  input  rsb_pkg::cfg_t      cfg,
  output rsb_pkg::span_res_t res
);

  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_CMD     = 2'd1;
  localparam logic [1:0] MODE_LITERAL = 2'd2;
  localparam logic [1:0] MODE_RUNVAL  = 2'd3;

  logic [1:0]                       parse_mode, parse_mode_next;
  logic [7:0]                       literal_left, literal_left_next;
  logic [7:0]                       run_length, run_length_next;
  logic signed [rsb_pkg::ROW_W-1:0] pen_row, pen_row_next;
  logic signed [rsb_pkg::COL_W-1:0] pen_col, pen_col_next;
  logic signed [rsb_pkg::XY_W-1:0]  row_start_col, row_start_col_next;

  rsb_pkg::span_req_t               req;
  rsb_pkg::span_res_t               clip;
  logic                             emit;
  logic signed [rsb_pkg::XY_W-1:0]  x, y;
  logic signed [rsb_pkg::ROW_W-1:0] xw, yh, fw_s, fh_s, row_inc;
  logic signed [rsb_pkg::COL_W:0]   col_sum;
  logic signed [rsb_pkg::COL_W-1:0] col_adv;
  logic                             reject;
  logic [7:0]                       b;

  rsb_span_clip u_clip (
    .cfg (cfg),
    .req (req),
    .res (clip)
  );

  assign b    = item.stream_byte;
  assign fw_s = signed'(rsb_pkg::ROW_W'(cfg.side_w));
  assign fh_s = signed'(rsb_pkg::ROW_W'(cfg.side_h));

  // Frame entry geometry and reject test
  always_comb begin
    x      = rsb_pkg::XY_W'(item.pos_x) - rsb_pkg::XY_W'(item.hot_x);
    y      = rsb_pkg::XY_W'(item.pos_y) - rsb_pkg::XY_W'(item.hot_y);
    xw     = rsb_pkg::ROW_W'(x) + signed'(rsb_pkg::ROW_W'(item.sprite_width));
    yh     = rsb_pkg::ROW_W'(y) + signed'(rsb_pkg::ROW_W'(item.sprite_height));
    reject = (rsb_pkg::ROW_W'(x) >= fw_s) || (rsb_pkg::ROW_W'(y) >= fh_s) ||
             (xw <= 0) || (yh <= 0) || (!x[rsb_pkg::XY_W-1] && (xw > fw_s));
  end

  // Saturating column advance by the span length
  always_comb begin
    col_sum = (rsb_pkg::COL_W+1)'(pen_col) + signed'((rsb_pkg::COL_W+1)'(req.len));
    if (col_sum > signed'({2'b00, {(rsb_pkg::COL_W-1){1'b1}}})) begin
      col_adv = signed'({1'b0, {(rsb_pkg::COL_W-1){1'b1}}});
    end else begin
      col_adv = col_sum[rsb_pkg::COL_W-1:0];
    end
  end

  // Command decode and pen update
  always_comb begin
    parse_mode_next    = parse_mode;
    literal_left_next  = literal_left;
    run_length_next    = run_length;
    pen_row_next       = pen_row;
    pen_col_next       = pen_col;
    row_start_col_next = row_start_col;
    row_inc            = pen_row + rsb_pkg::ROW_W'(1);
    emit               = 1'b0;
    req.row            = pen_row;
    req.col            = pen_col;
    req.len            = 8'd1;
    req.value          = b;
    if (!item.kind) begin
      literal_left_next  = '0;
      run_length_next    = '0;
      pen_row_next       = rsb_pkg::ROW_W'(y);
      pen_col_next       = rsb_pkg::COL_W'(x);
      row_start_col_next = x;
      parse_mode_next    = reject ? MODE_STOPPED : MODE_CMD;
    end else begin
      unique case (parse_mode)
        MODE_CMD: begin
          if (b == rsb_pkg::CMD_STOP) begin
            parse_mode_next = MODE_STOPPED;
          end else if (b == cfg.row_break_code) begin
            pen_row_next = row_inc;
            pen_col_next = rsb_pkg::COL_W'(row_start_col);
            if (row_inc >= fh_s) begin
              parse_mode_next = MODE_STOPPED;
            end
          end else if (b < rsb_pkg::LITERAL_LIMIT) begin
            literal_left_next = b + 8'd1;
            parse_mode_next   = MODE_LITERAL;
          end else begin
            run_length_next = b - rsb_pkg::RUN_BIAS;
            parse_mode_next = MODE_RUNVAL;
          end
        end
        MODE_LITERAL: begin
          if (literal_left <= 8'd1) begin
            literal_left_next = '0;
            parse_mode_next   = MODE_CMD;
          end else begin
            literal_left_next = literal_left - 8'd1;
          end
          emit         = 1'b1;
          pen_col_next = col_adv;
        end
        MODE_RUNVAL: begin
          req.len         = run_length;
          run_length_next = '0;
          parse_mode_next = MODE_CMD;
          emit            = 1'b1;
          pen_col_next    = col_adv;
        end
        MODE_STOPPED: ;
      endcase
    end
    res.hit  = emit && clip.hit;
    res.span = clip.span;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= MODE_STOPPED;
      literal_left  <= '0;
      run_length    <= '0;
      pen_row       <= '0;
      pen_col       <= '0;
      row_start_col <= '0;
    end else if (go) begin
      parse_mode    <= parse_mode_next;
      literal_left  <= literal_left_next;
      run_length    <= run_length_next;
      pen_row       <= pen_row_next;
      pen_col       <= pen_col_next;
      row_start_col <= row_start_col_next;
    end
  end

endmodule

// ----- rtl/core/rle_sprite_clipped_blitter.sv -----
// Channel  Dir  Handshake                 Payload
// item     in   item_valid / item_stall   rsb_pkg::item_t
// span     out  span_valid / span_stall   rsb_pkg::span_t
// cfg      in   APB write, pready high    fb_width, fb_height, row_break_code
//
// One item per cycle unless the span side stalls; a byte passes the input register, then the span register.
// The pen update (column add with saturation, row base multiply, clip) is a
// combinational path between the input register and the span register.
// Synchronous reset clears the parser to stopped and the registers to
// 600, 360 and 254. A stalled span holds and stalls the item side.
module rle_sprite_clipped_blitter #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  rsb_pkg::item_t              item,
  output logic                        span_valid,
  input  logic                        span_stall,
  output rsb_pkg::span_t              span,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsb_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsb_pkg::DATA_W-1:0]  pwdata,
  output logic [rsb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  rsb_pkg::cfg_t      cfg;
  rsb_pkg::item_t     in_item;
  rsb_pkg::span_res_t res;
  logic               in_full;
  logic               advance;
  logic               take;
  logic               go;

  rsb_cfg_regs #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsb_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Handshake: the input register moves whenever the span register can load
  assign advance    = !span_valid || !span_stall;
  assign item_stall = in_full && !advance;
  assign take       = item_valid && !item_stall;
  assign go         = in_full && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= item;
    end
  end

  // Span register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (advance) begin
      span_valid <= go && res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.hit) begin
      span <= res.span;
    end
  end

endmodule
